// ----- src/sllbb_pkg.sv -----
// shared types and constants of the status led blink and breathe controller
package sllbb_pkg;

	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned PROD_W     = 24;
	localparam int unsigned DIV_CNT_W  = 5;

	localparam logic [DIV_CNT_W-1:0] STEP_ITERS  = 5'd16;

	localparam logic [2:0] MD_LOWBATT = 3'd0;
	localparam logic [2:0] MD_IDLE    = 3'd1;
	localparam logic [2:0] MD_CHARGE  = 3'd2;
	localparam logic [2:0] MD_FAULT   = 3'd3;
	localparam logic [2:0] MD_INIT    = 3'd4;

	localparam logic [1:0] LED_MODE_FAULT = 2'd3;

	localparam logic [1:0] FLT_NONE     = 2'd0;
	localparam logic [1:0] FLT_BAD_BATT = 2'd1;
	localparam logic [1:0] FLT_SENSOR   = 2'd2;
	localparam logic [1:0] FLT_TEMP     = 2'd3;

	localparam logic [1:0] PH_OFF  = 2'd0;
	localparam logic [1:0] PH_ON   = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;
	localparam logic [1:0] PH_UP   = 2'd0;
	localparam logic [1:0] PH_DOWN = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LEVEL  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PERIOD  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWB_PERIOD  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_PERIOD = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_STEPS  = 4'd7;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic mul;
		logic scale;
		logic div_start;
		logic peak;
		logic fin;
		logic out_load;
	} sllbb_cmd_t;

	typedef struct packed {
		logic need_pulse;
		logic div_busy;
	} sllbb_status_t;

endpackage

// ----- src/sllbb_if.sv -----
// request channels of the status led controller: tick, status and configuration
interface sllbb_tick_if;
	logic        valid;
	logic        ready;
	logic        bad_battery;
	logic        sensor_missing;
	logic        temp_limited;
	logic        low_batt_off;
	logic        charger_idle;
	logic [15:0] solar_current_ma;

	modport source (output valid, output bad_battery, output sensor_missing,
		output temp_limited, output low_batt_off, output charger_idle,
		output solar_current_ma, input ready);
	modport sink (input valid, input bad_battery, input sensor_missing,
		input temp_limited, input low_batt_off, input charger_idle,
		input solar_current_ma, output ready);
endinterface

interface sllbb_status_if;
	logic       valid;
	logic       ready;
	logic [7:0] led_level;
	logic [9:0] pwm_compare;
	logic       pwm_enable;
	logic [1:0] led_mode;
	logic [1:0] fault_kind;

	modport source (output valid, output led_level, output pwm_compare,
		output pwm_enable, output led_mode, output fault_kind, input ready);
	modport sink (input valid, input led_level, input pwm_compare,
		input pwm_enable, input led_mode, input fault_kind, output ready);
endinterface

interface sllbb_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/sllbb_div.sv -----
// serial restoring divider, one quotient bit per cycle
module sllbb_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [sllbb_pkg::PROD_W-1:0]        dividend,
	input  logic [15:0]                         divisor,
	input  logic [sllbb_pkg::DIV_CNT_W-1:0]     iters,
	output logic                                busy,
	output logic [sllbb_pkg::PROD_W-1:0]        quotient
);

	logic [sllbb_pkg::PROD_W-1:0]    work_q;
	logic [15:0]                     rem_q;
	logic [15:0]                     dsr_q;
	logic [sllbb_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic [16:0]                     shifted;
	logic [16:0]                     diff;
	logic                            ge;

	assign shifted = {rem_q, work_q[sllbb_pkg::PROD_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[sllbb_pkg::PROD_W-2:0], ge};
			rem_q  <= ge ? diff[15:0] : shifted[15:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = work_q;

endmodule

// ----- src/sllbb_dp.sv -----
// datapath: configuration registers, mode and blink state, breathing ramp
module sllbb_dp #(
	parameter int unsigned SOLAR_MAX_MA          = 4000,
	parameter int unsigned BAD_BATT_BLINKS       = 2,
	parameter int unsigned MISSING_SENSOR_BLINKS = 3,
	parameter int unsigned TEMP_RANGE_BLINKS     = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sllbb_pkg::sllbb_cmd_t               cmd,
	output sllbb_pkg::sllbb_status_t            status,
	input  logic                                bad_battery,
	input  logic                                sensor_missing,
	input  logic                                temp_limited,
	input  logic                                low_batt_off,
	input  logic                                charger_idle,
	input  logic [15:0]                         solar_current_ma,
	input  logic                                cfg_we,
	input  logic [sllbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sllbb_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [7:0]                          led_level,
	output logic [9:0]                          pwm_compare,
	output logic                                pwm_enable,
	output logic [1:0]                          led_mode,
	output logic [1:0]                          fault_kind
);

	// reciprocal of the full-scale current, exact for every product below 2^PROD_W
	localparam int unsigned SCALE_SH = sllbb_pkg::PROD_W + $clog2(SOLAR_MAX_MA);
	localparam logic [63:0] SCALE_RECIP_FULL =
		((64'd1 << SCALE_SH) + 64'(SOLAR_MAX_MA) - 64'd1) / 64'(SOLAR_MAX_MA);
	localparam logic [sllbb_pkg::PROD_W:0] SCALE_RECIP =
		SCALE_RECIP_FULL[sllbb_pkg::PROD_W:0];
	localparam logic [2:0]  BAD_N     = 3'(BAD_BATT_BLINKS);
	localparam logic [2:0]  SENSOR_N  = 3'(MISSING_SENSOR_BLINKS);
	localparam logic [2:0]  TEMP_N    = 3'(TEMP_RANGE_BLINKS);

	// latched tick
	logic        bad_q, miss_q, temp_q, lowb_q, cidle_q;
	logic [15:0] cur_q;

	// configuration
	logic [15:0] off_ticks_q, on_ticks_q, idle_period_q, lowb_period_q, fault_period_q;
	logic [7:0]  blink_level_q, pulse_min_q, pulse_steps_q;

	// state
	logic [2:0]  mode_q;
	logic [1:0]  fault_q, phase_q;
	logic [15:0] tick_q, wait_q, step_q;
	logic [2:0]  done_q, total_q;
	logic [7:0]  level_q, peak_q;
	logic [16:0] acc_q;
	logic [sllbb_pkg::PROD_W-1:0] prod_q;
	logic [sllbb_pkg::PROD_W-1:0] scale_q;

	// result
	logic [7:0] out_level_q;
	logic [1:0] out_mode_q, out_fault_q;

	logic [2:0]  mode_d, done_d, total_d;
	logic [1:0]  fault_d, phase_d;
	logic [15:0] tick_d, wait_d;
	logic [7:0]  level_d;
	logic [16:0] acc_d;
	logic        need_pulse;

	logic [1:0]  f;
	logic [2:0]  s;
	logic        go_fault, go_normal, run_b, run_p;
	logic        sb;
	logic [15:0] sb_period;
	logic [2:0]  sb_count;
	logic [15:0] tick_inc;
	logic [2:0]  done_inc;
	logic [16:0] acc_up, acc_dn;

	logic                          div_busy;
	logic [sllbb_pkg::PROD_W-1:0]  div_q;
	logic [sllbb_pkg::PROD_W-1:0]  div_dividend;
	logic [15:0]                   div_divisor;
	logic [7:0]                    steps_eff;
	logic [sllbb_pkg::PROD_W:0]    peak_sum;
	logic [2*sllbb_pkg::PROD_W:0]  scale_prod;
	logic [2*sllbb_pkg::PROD_W:0]  scale_shr;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			bad_q   <= bad_battery;
			miss_q  <= sensor_missing;
			temp_q  <= temp_limited;
			lowb_q  <= low_batt_off;
			cidle_q <= charger_idle;
			cur_q   <= solar_current_ma;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_ticks_q    <= 16'd25;
			on_ticks_q     <= 16'd5;
			blink_level_q  <= 8'd128;
			idle_period_q  <= 16'd500;
			lowb_period_q  <= 16'd1000;
			fault_period_q <= 16'd500;
			pulse_min_q    <= 8'd16;
			pulse_steps_q  <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sllbb_pkg::CFG_BLINK_OFF:    off_ticks_q    <= cfg_data;
				sllbb_pkg::CFG_BLINK_ON:     on_ticks_q     <= cfg_data;
				sllbb_pkg::CFG_BLINK_LEVEL:  blink_level_q  <= cfg_data[7:0];
				sllbb_pkg::CFG_IDLE_PERIOD:  idle_period_q  <= cfg_data;
				sllbb_pkg::CFG_LOWB_PERIOD:  lowb_period_q  <= cfg_data;
				sllbb_pkg::CFG_FAULT_PERIOD: fault_period_q <= cfg_data;
				sllbb_pkg::CFG_PULSE_MIN:    pulse_min_q    <= cfg_data[7:0];
				sllbb_pkg::CFG_PULSE_STEPS:  pulse_steps_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// fault and mode selection
	always_comb begin
		if (bad_q) begin
			f = sllbb_pkg::FLT_BAD_BATT;
		end else if (miss_q) begin
			f = sllbb_pkg::FLT_SENSOR;
		end else if (temp_q) begin
			f = sllbb_pkg::FLT_TEMP;
		end else begin
			f = sllbb_pkg::FLT_NONE;
		end
		if (lowb_q) begin
			s = sllbb_pkg::MD_LOWBATT;
		end else if (cidle_q) begin
			s = sllbb_pkg::MD_IDLE;
		end else begin
			s = sllbb_pkg::MD_CHARGE;
		end
	end

	always_comb begin
		go_fault  = 1'b0;
		go_normal = 1'b0;
		run_b     = 1'b0;
		run_p     = 1'b0;
		if (mode_q == sllbb_pkg::MD_FAULT) begin
			if (f == sllbb_pkg::FLT_NONE) begin
				go_normal = 1'b1;
			end else if (f < fault_q) begin
				go_fault = 1'b1;
			end else begin
				run_b = 1'b1;
			end
		end else if (f != sllbb_pkg::FLT_NONE) begin
			go_fault = 1'b1;
		end else if (mode_q != s) begin
			go_normal = 1'b1;
		end else if (mode_q == sllbb_pkg::MD_CHARGE) begin
			run_p = 1'b1;
		end else begin
			run_b = 1'b1;
		end
	end

	assign tick_inc = tick_q + 16'd1;
	assign done_inc = done_q + 3'd1;
	assign acc_up   = acc_q + {1'b0, step_q};
	assign acc_dn   = acc_q - {1'b0, step_q};

	always_comb begin
		mode_d     = mode_q;
		fault_d    = fault_q;
		phase_d    = phase_q;
		tick_d     = tick_q;
		done_d     = done_q;
		total_d    = total_q;
		wait_d     = wait_q;
		level_d    = level_q;
		acc_d      = acc_q;
		need_pulse = 1'b0;
		sb         = 1'b0;
		sb_period  = fault_period_q;
		sb_count   = TEMP_N;

		if (go_fault) begin
			mode_d = sllbb_pkg::MD_FAULT;
			if (f != fault_q) begin
				fault_d   = f;
				sb        = 1'b1;
				sb_period = fault_period_q;
				unique case (f)
					sllbb_pkg::FLT_BAD_BATT: sb_count = BAD_N;
					sllbb_pkg::FLT_SENSOR:   sb_count = SENSOR_N;
					default:                 sb_count = TEMP_N;
				endcase
			end
		end

		if (go_normal) begin
			fault_d = sllbb_pkg::FLT_NONE;
			if (s != mode_q) begin
				mode_d = s;
				unique case (s)
					sllbb_pkg::MD_IDLE: begin
						sb        = 1'b1;
						sb_period = idle_period_q;
						sb_count  = 3'd1;
					end
					sllbb_pkg::MD_LOWBATT: begin
						sb        = 1'b1;
						sb_period = lowb_period_q;
						sb_count  = 3'd1;
					end
					default: need_pulse = 1'b1;
				endcase
			end
		end

		if (run_b) begin
			case (phase_q)
				sllbb_pkg::PH_OFF: begin
					tick_d = tick_inc;
					if (tick_inc == off_ticks_q) begin
						tick_d  = '0;
						phase_d = sllbb_pkg::PH_ON;
						level_d = blink_level_q;
					end
				end
				sllbb_pkg::PH_ON: begin
					tick_d = tick_inc;
					if (tick_inc == on_ticks_q) begin
						tick_d  = '0;
						level_d = '0;
						done_d  = done_inc;
						phase_d = (done_inc == total_q) ? sllbb_pkg::PH_WAIT : sllbb_pkg::PH_OFF;
					end
				end
				sllbb_pkg::PH_WAIT: begin
					tick_d = tick_inc;
					if (tick_inc == wait_q) begin
						tick_d  = '0;
						phase_d = sllbb_pkg::PH_OFF;
						done_d  = '0;
					end
				end
				default: begin
					phase_d = sllbb_pkg::PH_OFF;
					tick_d  = '0;
					done_d  = '0;
					level_d = '0;
				end
			endcase
		end

		if (run_p) begin
			case (phase_q)
				sllbb_pkg::PH_UP: begin
					acc_d = acc_up;
					if (acc_up[16:8] >= {1'b0, peak_q}) begin
						level_d = peak_q;
						phase_d = sllbb_pkg::PH_DOWN;
					end else begin
						level_d = acc_up[15:8];
					end
				end
				sllbb_pkg::PH_DOWN: begin
					acc_d   = acc_dn;
					level_d = acc_dn[16] ? 8'hFF : acc_dn[15:8];
					if (acc_dn == '0) begin
						need_pulse = 1'b1;
					end
				end
				default: need_pulse = 1'b1;
			endcase
		end

		if (sb) begin
			level_d = '0;
			total_d = sb_count;
			done_d  = '0;
			wait_d  = sb_period;
			tick_d  = '0;
			phase_d = sllbb_pkg::PH_OFF;
		end
	end

	// pulse set-up: peak from solar current, then ramp step from peak
	assign steps_eff = (pulse_steps_q == '0) ? 8'd1 : pulse_steps_q;
	assign peak_sum  = {1'b0, scale_q} + {{(sllbb_pkg::PROD_W-7){1'b0}}, pulse_min_q};

	assign scale_prod = prod_q * SCALE_RECIP;
	assign scale_shr  = scale_prod >> SCALE_SH;

	assign div_dividend = {peak_q, 16'd0};
	assign div_divisor  = {8'd0, steps_eff};

	sllbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.iters    (sllbb_pkg::STEP_ITERS),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= (8'hFF - pulse_min_q) * cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scale_q <= scale_shr[sllbb_pkg::PROD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sllbb_pkg::MD_INIT;
			fault_q <= sllbb_pkg::FLT_NONE;
			phase_q <= sllbb_pkg::PH_OFF;
			tick_q  <= '0;
			done_q  <= '0;
			total_q <= '0;
			wait_q  <= '0;
			level_q <= '0;
			peak_q  <= '0;
			step_q  <= '0;
			acc_q   <= '0;
		end else begin
			if (cmd.eval) begin
				mode_q  <= mode_d;
				fault_q <= fault_d;
				phase_q <= phase_d;
				tick_q  <= tick_d;
				done_q  <= done_d;
				total_q <= total_d;
				wait_q  <= wait_d;
				level_q <= level_d;
				acc_q   <= acc_d;
			end
			if (cmd.peak) begin
				peak_q <= (peak_sum > 255) ? 8'hFF : peak_sum[7:0];
			end
			if (cmd.fin) begin
				step_q  <= div_q[15:0];
				level_q <= '0;
				acc_q   <= '0;
				phase_q <= sllbb_pkg::PH_UP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_level_q <= level_q;
			out_mode_q  <= mode_q[1:0];
			out_fault_q <= fault_q;
		end
	end

	assign status.need_pulse = need_pulse;
	assign status.div_busy   = div_busy;

	assign led_level   = out_level_q;
	assign pwm_compare = 10'h3FF - {out_level_q, 2'b00};
	assign pwm_enable  = out_level_q != '0;
	assign led_mode    = out_mode_q;
	assign fault_kind  = out_fault_q;

endmodule

// ----- src/sllbb_ctrl.sv -----
// controller: request handshakes and sequencing of the evaluation and pulse set-up
module sllbb_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tick_valid,
	output logic                     tick_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  sllbb_pkg::sllbb_status_t status,
	output sllbb_pkg::sllbb_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EVAL  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_SCALE = 4'd3;
	localparam logic [3:0] ST_PEAK  = 4'd4;
	localparam logic [3:0] ST_DIVS  = 4'd5;
	localparam logic [3:0] ST_DIVW  = 4'd6;
	localparam logic [3:0] ST_FIN   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.need_pulse ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_PEAK;
			end
			ST_PEAK: begin
				cmd.peak = 1'b1;
				state_d  = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (!status.div_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tick_ready = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;

endmodule

// ----- src/status_led_blink_breathe_top.sv -----
// top level of the status led blink and breathe controller
// Each tick request carries the fault flags, charger status and solar current and
// yields one status request with the LED level, PWM compare value, mode and fault
// code. A plain tick is evaluated and its result is then loaded into the output
// register, after which the next tick can be taken. A tick that sets up a new breathing
// pulse passes through further steps before its result is loaded: the peak is
// scaled from the solar current by a multiply and a reciprocal multiply, then the ramp
// step is derived from the peak by a serial divider. One tick is worked on at
// a time; the next is taken while the previous result still waits in the output
// register, and a result that is not taken holds back the one after it. Configuration
// writes are always accepted and are meant to be made while no tick is in flight.
module status_led_blink_breathe_top #(
	parameter int unsigned SOLAR_MAX_MA          = 4000,
	parameter int unsigned BAD_BATT_BLINKS       = 2,
	parameter int unsigned MISSING_SENSOR_BLINKS = 3,
	parameter int unsigned TEMP_RANGE_BLINKS     = 4
) (
	input logic          clk,
	input logic          arst_n,
	sllbb_tick_if.sink   tick,
	sllbb_status_if.source status,
	sllbb_cfg_if.sink    cfg
);

	sllbb_pkg::sllbb_cmd_t    cmd;
	sllbb_pkg::sllbb_status_t dp_status;

	assign cfg.ready = 1'b1;

	sllbb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.out_valid  (status.valid),
		.out_ready  (status.ready),
		.status     (dp_status),
		.cmd        (cmd)
	);

	sllbb_dp #(
		.SOLAR_MAX_MA          (SOLAR_MAX_MA),
		.BAD_BATT_BLINKS       (BAD_BATT_BLINKS),
		.MISSING_SENSOR_BLINKS (MISSING_SENSOR_BLINKS),
		.TEMP_RANGE_BLINKS     (TEMP_RANGE_BLINKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (dp_status),
		.bad_battery      (tick.bad_battery),
		.sensor_missing   (tick.sensor_missing),
		.temp_limited     (tick.temp_limited),
		.low_batt_off     (tick.low_batt_off),
		.charger_idle     (tick.charger_idle),
		.solar_current_ma (tick.solar_current_ma),
		.cfg_we           (cfg.valid && cfg.ready),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.led_level        (status.led_level),
		.pwm_compare      (status.pwm_compare),
		.pwm_enable       (status.pwm_enable),
		.led_mode         (status.led_mode),
		.fault_kind       (status.fault_kind)
	);

`ifndef SYNTH
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("tick taken while previous tick still in work");

	a_fault_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		status.valid && status.led_mode == sllbb_pkg::LED_MODE_FAULT
		|-> status.fault_kind != sllbb_pkg::FLT_NONE)
		else $error("fault mode reported without a fault kind");

	a_normal_no_kind: assert property (@(posedge clk) disable iff (!arst_n)
		status.valid && status.led_mode != sllbb_pkg::LED_MODE_FAULT
		|-> status.fault_kind == sllbb_pkg::FLT_NONE)
		else $error("fault kind reported outside fault mode");
`endif

endmodule

// ----- dv/tb_top.sv -----
// testbench of the status led controller: random and directed ticks checked against a predictor
module tb_top;
	import sllbb_pkg::*;

	localparam int unsigned SOLAR_MAX_MA          = 4000;
	localparam int unsigned BAD_BATT_BLINKS       = 2;
	localparam int unsigned MISSING_SENSOR_BLINKS = 3;
	localparam int unsigned TEMP_RANGE_BLINKS     = 4;
	localparam logic [9:0]  PWM_TOP               = 10'd1023;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG   = 4'd12;
	localparam int unsigned HOLD_CYCLES           = 300;

	typedef struct packed {
		logic        bad_battery;
		logic        sensor_missing;
		logic        temp_limited;
		logic        low_batt_off;
		logic        charger_idle;
		logic [15:0] solar_current_ma;
	} tick_req_t;

	typedef struct packed {
		logic [7:0] led_level;
		logic [9:0] pwm_compare;
		logic       pwm_enable;
		logic [1:0] led_mode;
		logic [1:0] fault_kind;
	} led_status_t;

	logic clk = 1'b0;
	logic arst_n;

	sllbb_tick_if   tick_ch ();
	sllbb_status_if status_ch ();
	sllbb_cfg_if    cfg_ch ();

	status_led_blink_breathe_top #(
		.SOLAR_MAX_MA          (SOLAR_MAX_MA),
		.BAD_BATT_BLINKS       (BAD_BATT_BLINKS),
		.MISSING_SENSOR_BLINKS (MISSING_SENSOR_BLINKS),
		.TEMP_RANGE_BLINKS     (TEMP_RANGE_BLINKS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.status (status_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// predictor copy of the timing registers
	logic [15:0] off_len, on_len, idle_len, lowb_len, fault_len;
	logic [7:0]  blink_lvl, breathe_floor, breathe_steps;

	// predictor copy of the controller state
	logic [2:0]  led_mode_q;
	logic [1:0]  fault_q, phase_q;
	logic [15:0] tick_cnt_q, wait_len_q, ramp_step_q;
	logic [2:0]  blinks_q, blink_goal_q;
	logic [7:0]  level_q, peak_q;
	logic [16:0] ramp_acc_q;

	tick_req_t   ticks_to_send[$];
	led_status_t status_expected[$];

	int unsigned send_idle_pct, recv_stall_pct;
	int unsigned hold_ticket, hold_seen, hold_left;
	int unsigned ticks_sent, statuses_checked, reg_writes, mismatches, settings_run;
	int unsigned run_left;
	logic [4:0]  held_flags;
	logic        tick_acc;

	function automatic void reset_predictor();
		off_len = 16'd25;
		on_len = 16'd5;
		blink_lvl = 8'd128;
		idle_len = 16'd500;
		lowb_len = 16'd1000;
		fault_len = 16'd500;
		breathe_floor = 8'd16;
		breathe_steps = 8'd128;
		led_mode_q = MD_INIT;
		fault_q = FLT_NONE;
		phase_q = PH_OFF;
		tick_cnt_q = '0;
		blinks_q = '0;
		blink_goal_q = '0;
		wait_len_q = '0;
		level_q = '0;
		peak_q = '0;
		ramp_step_q = '0;
		ramp_acc_q = '0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		case (idx)
			CFG_BLINK_OFF:    off_len = val;
			CFG_BLINK_ON:     on_len = val;
			CFG_BLINK_LEVEL:  blink_lvl = val[7:0];
			CFG_IDLE_PERIOD:  idle_len = val;
			CFG_LOWB_PERIOD:  lowb_len = val;
			CFG_FAULT_PERIOD: fault_len = val;
			CFG_PULSE_MIN:    breathe_floor = val[7:0];
			CFG_PULSE_STEPS:  breathe_steps = val[7:0];
			default: ;
		endcase
	endfunction

	function automatic void begin_blinks(logic [15:0] period, logic [2:0] count);
		level_q = '0;
		blink_goal_q = count;
		blinks_q = '0;
		wait_len_q = period;
		tick_cnt_q = '0;
		phase_q = PH_OFF;
	endfunction

	function automatic void begin_breath(logic [15:0] current);
		int unsigned span, lvl, steps, pk;
		span = 255 - breathe_floor;
		lvl = span * current / SOLAR_MAX_MA + breathe_floor;
		peak_q = (lvl > 255) ? 8'd255 : 8'(lvl);
		steps = (breathe_steps == 0) ? 1 : breathe_steps;
		pk = peak_q;
		ramp_step_q = 16'((pk << 8) / steps);
		level_q = '0;
		ramp_acc_q = '0;
		phase_q = PH_UP;
	endfunction

	function automatic void enter_fault(logic [1:0] f);
		logic [2:0] n;
		led_mode_q = MD_FAULT;
		if (f != fault_q) begin
			fault_q = f;
			case (f)
				FLT_BAD_BATT: n = 3'(BAD_BATT_BLINKS);
				FLT_SENSOR:   n = 3'(MISSING_SENSOR_BLINKS);
				default:      n = 3'(TEMP_RANGE_BLINKS);
			endcase
			begin_blinks(fault_len, n);
		end
	endfunction

	function automatic void enter_normal(logic [2:0] s, logic [15:0] current);
		fault_q = FLT_NONE;
		if (s != led_mode_q) begin
			led_mode_q = s;
			if (s == MD_IDLE)
				begin_blinks(idle_len, 3'd1);
			else if (s == MD_LOWBATT)
				begin_blinks(lowb_len, 3'd1);
			else
				begin_breath(current);
		end
	endfunction

	function automatic void run_blink();
		if (phase_q == PH_OFF) begin
			tick_cnt_q = tick_cnt_q + 16'd1;
			if (tick_cnt_q == off_len) begin
				tick_cnt_q = '0;
				phase_q = PH_ON;
				level_q = blink_lvl;
			end
		end else if (phase_q == PH_ON) begin
			tick_cnt_q = tick_cnt_q + 16'd1;
			if (tick_cnt_q == on_len) begin
				tick_cnt_q = '0;
				level_q = '0;
				blinks_q = blinks_q + 3'd1;
				phase_q = (blinks_q == blink_goal_q) ? PH_WAIT : PH_OFF;
			end
		end else if (phase_q == PH_WAIT) begin
			tick_cnt_q = tick_cnt_q + 16'd1;
			if (tick_cnt_q == wait_len_q) begin
				tick_cnt_q = '0;
				phase_q = PH_OFF;
				blinks_q = '0;
			end
		end else begin
			phase_q = PH_OFF;
			tick_cnt_q = '0;
			blinks_q = '0;
			level_q = '0;
		end
	endfunction

	function automatic void run_breath(logic [15:0] current);
		logic [8:0] lv;
		if (phase_q == PH_UP) begin
			ramp_acc_q = ramp_acc_q + {1'b0, ramp_step_q};
			lv = ramp_acc_q[16:8];
			if (lv >= {1'b0, peak_q}) begin
				level_q = peak_q;
				phase_q = PH_DOWN;
			end else begin
				level_q = lv[7:0];
			end
		end else if (phase_q == PH_DOWN) begin
			ramp_acc_q = ramp_acc_q - {1'b0, ramp_step_q};
			lv = ramp_acc_q[16:8];
			level_q = lv[8] ? 8'd255 : lv[7:0];
			if (ramp_acc_q == '0)
				begin_breath(current);
		end else begin
			begin_breath(current);
		end
	endfunction

	function automatic led_status_t predict_status(tick_req_t t);
		logic [1:0]  f;
		logic [2:0]  s;
		led_status_t r;
		if (t.bad_battery)
			f = FLT_BAD_BATT;
		else if (t.sensor_missing)
			f = FLT_SENSOR;
		else if (t.temp_limited)
			f = FLT_TEMP;
		else
			f = FLT_NONE;
		if (t.low_batt_off)
			s = MD_LOWBATT;
		else if (t.charger_idle)
			s = MD_IDLE;
		else
			s = MD_CHARGE;

		if (led_mode_q == MD_FAULT) begin
			if (f == FLT_NONE)
				enter_normal(s, t.solar_current_ma);
			else if (f < fault_q)
				enter_fault(f);
			else
				run_blink();
		end else if (f != FLT_NONE) begin
			enter_fault(f);
		end else if (led_mode_q != s) begin
			enter_normal(s, t.solar_current_ma);
		end else if (led_mode_q == MD_CHARGE) begin
			run_breath(t.solar_current_ma);
		end else begin
			run_blink();
		end

		r.led_level = level_q;
		r.pwm_compare = PWM_TOP - {level_q, 2'b00};
		r.pwm_enable = (level_q != 0);
		r.led_mode = led_mode_q[1:0];
		r.fault_kind = fault_q;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s expected %0d got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// flags mostly stay put for a run of ticks so the blink and ramp cycles get to play out
	function automatic tick_req_t make_tick(int unsigned max_run);
		tick_req_t t;
		if (run_left == 0) begin
			run_left = $urandom_range(max_run, 1);
			if ($urandom_range(99) < 65)
				held_flags = {3'b000, 2'($urandom)};
			else
				held_flags = 5'($urandom);
		end
		run_left--;
		{t.bad_battery, t.sensor_missing, t.temp_limited, t.low_batt_off, t.charger_idle} =
			($urandom_range(99) < 4) ? 5'($urandom) : held_flags;
		case ($urandom_range(5))
			0:       t.solar_current_ma = '0;
			1:       t.solar_current_ma = 16'hFFFF;
			2:       t.solar_current_ma = 16'(SOLAR_MAX_MA);
			3:       t.solar_current_ma = 16'($urandom_range(SOLAR_MAX_MA));
			default: t.solar_current_ma = 16'($urandom);
		endcase
		return t;
	endfunction

	task automatic push_tick(logic b, logic sm, logic tl, logic lb, logic ci, logic [15:0] cur);
		tick_req_t t;
		t = {b, sm, tl, lb, ci, cur};
		ticks_to_send.push_back(t);
	endtask

	task automatic queue_random(int unsigned n, int unsigned max_run);
		run_left = 0;
		repeat (n) ticks_to_send.push_back(make_tick(max_run));
	endtask

	task automatic drain();
		while (ticks_to_send.size() != 0 || tick_ch.valid || status_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_timing(logic [15:0] off_t, logic [15:0] on_t, logic [7:0] lvl,
			logic [15:0] idle_t, logic [15:0] lowb_t, logic [15:0] fault_t,
			logic [7:0] floor_lvl, logic [7:0] steps);
		drain();
		write_reg(CFG_BLINK_OFF, off_t);
		write_reg(CFG_BLINK_ON, on_t);
		write_reg(CFG_BLINK_LEVEL, {8'd0, lvl});
		write_reg(CFG_IDLE_PERIOD, idle_t);
		write_reg(CFG_LOWB_PERIOD, lowb_t);
		write_reg(CFG_FAULT_PERIOD, fault_t);
		write_reg(CFG_PULSE_MIN, {8'd0, floor_lvl});
		write_reg(CFG_PULSE_STEPS, {8'd0, steps});
		settings_run++;
	endtask

	// tick request driver
	always @(negedge clk) begin : tick_driver
		tick_req_t nxt;
		if (arst_n && (!tick_ch.valid || tick_acc)) begin
			if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = ticks_to_send.pop_front();
				tick_ch.valid <= 1'b1;
				tick_ch.bad_battery <= nxt.bad_battery;
				tick_ch.sensor_missing <= nxt.sensor_missing;
				tick_ch.temp_limited <= nxt.temp_limited;
				tick_ch.low_batt_off <= nxt.low_batt_off;
				tick_ch.charger_idle <= nxt.charger_idle;
				tick_ch.solar_current_ma <= nxt.solar_current_ma;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// status request sink with random stalls and a long hold-off on demand
	always @(negedge clk) begin : status_sink
		if (hold_left > 0) begin
			status_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			status_ch.ready <= 1'b0;
		end else begin
			status_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : status_monitor
		tick_req_t   t;
		led_status_t exp_s;
		tick_acc <= tick_ch.valid && tick_ch.ready;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				apply_reg(cfg_ch.index, cfg_ch.data);
				reg_writes++;
			end
			if (tick_ch.valid && tick_ch.ready) begin
				t = {tick_ch.bad_battery, tick_ch.sensor_missing, tick_ch.temp_limited,
					tick_ch.low_batt_off, tick_ch.charger_idle, tick_ch.solar_current_ma};
				status_expected.push_back(predict_status(t));
				ticks_sent++;
			end
			if (status_ch.valid && status_ch.ready) begin
				if (status_expected.size() == 0) begin
					$error("status request with no tick waiting for it");
					mismatches++;
				end else begin
					exp_s = status_expected.pop_front();
					check_field("led_level", exp_s.led_level, status_ch.led_level);
					check_field("pwm_compare", exp_s.pwm_compare, status_ch.pwm_compare);
					check_field("pwm_enable", exp_s.pwm_enable, status_ch.pwm_enable);
					check_field("led_mode", exp_s.led_mode, status_ch.led_mode);
					check_field("fault_kind", exp_s.fault_kind, status_ch.fault_kind);
					statuses_checked++;
				end
			end
		end
	end

	initial begin : run_limit
		#10000000;
		$display("[status_led_blink_breathe_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.bad_battery = 1'b0;
		tick_ch.sensor_missing = 1'b0;
		tick_ch.temp_limited = 1'b0;
		tick_ch.low_batt_off = 1'b0;
		tick_ch.charger_idle = 1'b0;
		tick_ch.solar_current_ma = '0;
		status_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_ticket = 0;
		hold_seen = 0;
		hold_left = 0;
		ticks_sent = 0;
		statuses_checked = 0;
		reg_writes = 0;
		mismatches = 0;
		settings_run = 1;
		run_left = 0;
		held_flags = '0;
		reset_predictor();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset timing: first tick set-up, every mode, fault priorities, current extremes
		push_tick(0, 0, 0, 0, 0, 16'd0);
		push_tick(0, 0, 0, 0, 0, 16'hFFFF);
		push_tick(0, 0, 0, 0, 0, 16'd4000);
		push_tick(0, 0, 0, 0, 1, 16'd0);
		push_tick(0, 0, 0, 0, 1, 16'd0);
		push_tick(0, 0, 0, 1, 0, 16'd0);
		push_tick(0, 0, 0, 1, 1, 16'd0);
		push_tick(0, 0, 1, 0, 0, 16'd0);
		push_tick(0, 1, 0, 0, 0, 16'd0);
		push_tick(1, 0, 0, 0, 0, 16'd0);
		push_tick(0, 0, 1, 0, 0, 16'd0);
		push_tick(1, 1, 1, 1, 1, 16'hFFFF);
		push_tick(0, 0, 0, 0, 0, 16'hFFFF);
		push_tick(0, 0, 0, 0, 0, 16'd0);
		push_tick(0, 0, 0, 0, 0, 16'h8000);
		push_tick(0, 0, 0, 0, 1, 16'd0);

		// shortest timing, dark breathing floor, single-step ramp
		set_timing(16'd1, 16'd1, 8'd255, 16'd1, 16'd1, 16'd1, 8'd0, 8'd1);
		write_reg(CFG_NO_REG, 16'hFFFF);
		repeat (6) push_tick(0, 0, 0, 0, 0, 16'd0);
		push_tick(0, 0, 0, 0, 0, 16'd1);
		push_tick(0, 0, 0, 0, 0, 16'd15);
		queue_random(200, 12);
		hold_ticket++;
		drain();
		queue_random(180, 12);

		// sender idles half the time
		set_timing(16'd3, 16'd2, 8'($urandom), 16'($urandom_range(9, 2)),
			16'($urandom_range(9, 2)), 16'($urandom_range(9, 2)), 8'($urandom),
			8'($urandom_range(6, 1)));
		send_idle_pct = 50;
		queue_random(380, 40);

		// longest timing, dark blinks, full breathing peak at any current
		set_timing(16'hFFFF, 16'hFFFF, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		queue_random(380, 300);

		// both sides idle now and then
		set_timing(16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)), 8'($urandom),
			16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
			8'($urandom), 8'($urandom_range(20, 1)));
		send_idle_pct = 10;
		recv_stall_pct = 10;
		queue_random(380, 30);

		set_timing(16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)), 8'($urandom),
			16'($urandom_range(50, 1)), 16'($urandom_range(50, 1)), 16'($urandom_range(50, 1)),
			8'($urandom), 8'($urandom_range(40, 1)));
		queue_random(380, 80);

		drain();
		repeat (60) @(posedge clk);
		if (status_expected.size() != 0) begin
			$error("%0d status requests never arrived", status_expected.size());
			mismatches++;
		end
		$display("ran %0d ticks under %0d timing settings with %0d register writes",
			ticks_sent, settings_run, reg_writes);
		$display("compared %0d status requests, %0d mismatches", statuses_checked, mismatches);
		if (mismatches == 0)
			$display("[status_led_blink_breathe_top] OK");
		else
			$display("[status_led_blink_breathe_top] ERROR");
		$finish;
	end

endmodule
